// File: hw/rtl/framed_byte_ring_buffer_unit_defines.svh
// ----------------------------------------------------------------------------
// framed byte ring buffer assertion macros
// property shapes for the checks at the end of framed_byte_ring_buffer_unit
// ----------------------------------------------------------------------------
`ifndef FRAMED_BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define FRAMED_BYTE_RING_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FRB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/frb_pkg.sv
// ----------------------------------------------------------------------------
// frb_pkg
// field widths and codes shared by the ring buffer and its channel interfaces
// ----------------------------------------------------------------------------
package frb_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 12;
    localparam int STATUS_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVAL   = 3'd1,
        ST_NOSPACE = 3'd2,
        ST_SIZE    = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

endpackage

// File: hw/rtl/frb_ifs.sv
// ----------------------------------------------------------------------------
// frb channel interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface frb_item_if;
    import frb_pkg::*;

    logic                valid;
    logic                ready;
    t_action             action;
    logic [BYTE_W-1:0]   data_byte;
    logic [FIELD_W-1:0]  length;
    logic [FIELD_W-1:0]  position;

    modport source (output valid, action, data_byte, length, position, input ready);
    modport sink   (input valid, action, data_byte, length, position, output ready);
endinterface

interface frb_result_if;
    import frb_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   read_byte;
    logic                last;
    logic [FIELD_W-1:0]  write_position;
    logic [FIELD_W-1:0]  free_bytes;
    logic [FIELD_W-1:0]  used_bytes;

    modport source (output valid, status, read_byte, last, write_position, free_bytes,
                    used_bytes, input ready);
    modport sink   (input valid, status, read_byte, last, write_position, free_bytes,
                    used_bytes, output ready);
endinterface

// File: hw/rtl/framed_byte_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// framed_byte_ring_buffer_unit
// byte ring buffer with burst-checked writes, random-access read runs,
// frame release and a status query
// ----------------------------------------------------------------------------
// The block takes one request at a time and registers it at its transfer. A
// write or query request is decided in S_EVAL, which follows the transfer
// and waits until the output register is free; its result then goes into
// the output register and the block returns to idle for the next request.
// Read-run and finish-frame requests first reduce the position modulo
// BUF_BYTES and turn it into an offset from the read pointer in a
// three-stage front end (S_POS1, S_POS2, S_REL). Their decision, and any
// finish or error result, follows in S_EVAL. An accepted read run fetches its
// first byte into the memory read register at the decision, moves it to the
// output register in S_RDOUT and then streams one byte per cycle from the
// memory read port as long as the result side takes them. A result that waits
// in the output register while the next one is due holds the block back. A
// new request is taken once the previous one has produced its last result
// into the output register, even if that result still waits there. The byte
// memory has no reset and no clearing pass; reads only reach bytes that an
// accepted burst has already written. Every result carries the committed write
// pointer and the free and used byte counts after the request, cut to 12 bits.
// ----------------------------------------------------------------------------
module framed_byte_ring_buffer_unit #(
    parameter int BUF_BYTES = 4096,
    parameter int READ_MAX  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    frb_item_if.sink            i_item,
    frb_result_if.source        o_result
);
    import frb_pkg::*;

    `include "framed_byte_ring_buffer_unit_defines.svh"

    // pointer and count widths
    localparam int AW        = $clog2(BUF_BYTES);
    localparam int W         = (AW > FIELD_W) ? AW : FIELD_W;
    localparam int CW        = $clog2(READ_MAX + 1);
    localparam int MOD_SHIFT = 24;
    // reciprocal for the position reduction, only used below 4096 entries
    localparam int MUL_K     = (BUF_BYTES < 4096) ?
                               ((1 << MOD_SHIFT) + BUF_BYTES - 1) / BUF_BYTES : 1;
    localparam logic [MOD_SHIFT:0] K_VEC  = (MOD_SHIFT+1)'(MUL_K);
    localparam logic [AW-1:0]      B_LAST = AW'(BUF_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS1,
        S_POS2,
        S_REL,
        S_EVAL,
        S_RDOUT
    } t_state;

    // control state
    t_state              r_state, n_state;
    logic [AW-1:0]       r_cw, n_cw;          // committed write pointer
    logic [AW-1:0]       r_rp, n_rp;          // read pointer
    logic [AW-1:0]       r_stg, n_stg;        // staging pointer of the open burst
    logic [AW-1:0]       r_used, n_used;      // used byte count
    logic [FIELD_W-1:0]  r_burst_rem, n_burst_rem;
    logic                r_burst_rej, n_burst_rej;
    logic [AW-1:0]       r_blen, n_blen;      // length of the open burst
    logic                r_out_valid, n_out_valid;

    // request and working payload
    t_action             r_act, n_act;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [FIELD_W-1:0]  r_len, n_len;
    logic [FIELD_W-1:0]  r_pos, n_pos;
    logic [36:0]         r_prod, n_prod;
    logic [AW-1:0]       r_posm, n_posm;
    logic [AW-1:0]       r_rel, n_rel;
    logic [AW-1:0]       r_rd_addr, n_rd_addr;
    logic [CW-1:0]       r_rd_cnt, n_rd_cnt;
    logic [CW-1:0]       r_rd_len, n_rd_len;

    // result register
    t_status             r_o_status;
    logic [BYTE_W-1:0]   r_o_byte;
    logic                r_o_last;
    logic [FIELD_W-1:0]  r_o_wp;
    logic [FIELD_W-1:0]  r_o_free;
    logic [FIELD_W-1:0]  r_o_used;

    // byte memory
    logic [BYTE_W-1:0]   r_store [BUF_BYTES];
    logic [BYTE_W-1:0]   r_mem_q;

    logic                w_slot;
    logic                w_emit;
    t_status             w_st;
    logic [BYTE_W-1:0]   w_obyte;
    logic                w_olast;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic                w_re;
    logic [AW-1:0]       w_raddr;
    logic [AW-1:0]       w_stg_eff;
    logic                w_rej_eff;
    logic [FIELD_W-1:0]  w_len_eff;
    logic [AW-1:0]       w_blen_eff;
    logic [W:0]          w_fill_sum;
    logic [W:0]          w_rd_end;
    logic [12:0]         w_q;
    logic [29:0]         w_qb;
    logic [FIELD_W-1:0]  w_posm12;
    logic [AW:0]         w_rel_sum;
    logic [AW-1:0]       w_free;
    logic [W-1:0]        w_wp_w;
    logic [W-1:0]        w_free_w;
    logic [W-1:0]        w_used_w;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == B_LAST) ? '0 : p + AW'(1);
    endfunction

    // output slot is free when empty or being drained this cycle
    assign w_slot = !r_out_valid || o_result.ready;

    // no transfer while reset is applied
    assign i_item.ready = i_rst_n && (r_state == S_IDLE);

    // position reduction and offset from the read pointer
    assign w_q      = r_prod[36:MOD_SHIFT];
    assign w_qb     = w_q * 17'(BUF_BYTES);
    assign w_posm12 = (BUF_BYTES >= 4096) ? r_pos : (r_pos - w_qb[FIELD_W-1:0]);
    assign w_rel_sum = (r_posm >= r_rp) ? {1'b0, r_posm - r_rp} :
                       ((AW+1)'(r_posm) + (AW+1)'(BUF_BYTES) - (AW+1)'(r_rp));

    // burst bookkeeping as seen by the current write
    assign w_stg_eff  = (r_burst_rem == '0) ? r_cw : r_stg;
    assign w_fill_sum = (W+1)'(r_used) + (W+1)'(r_len);
    assign w_rej_eff  = (r_burst_rem == '0) ? (w_fill_sum >= (W+1)'(BUF_BYTES)) : r_burst_rej;
    assign w_len_eff  = (r_burst_rem == '0) ? r_len : r_burst_rem;
    assign w_blen_eff = (r_burst_rem == '0) ? AW'(r_len) : r_blen;

    // end of a read run relative to the read pointer
    assign w_rd_end = (W+1)'(r_rel) + (W+1)'(r_len);

    always_comb begin
        n_state     = r_state;
        n_cw        = r_cw;
        n_rp        = r_rp;
        n_stg       = r_stg;
        n_used      = r_used;
        n_burst_rem = r_burst_rem;
        n_burst_rej = r_burst_rej;
        n_blen      = r_blen;
        n_act       = r_act;
        n_byte      = r_byte;
        n_len       = r_len;
        n_pos       = r_pos;
        n_prod      = r_prod;
        n_posm      = r_posm;
        n_rel       = r_rel;
        n_rd_addr   = r_rd_addr;
        n_rd_cnt    = r_rd_cnt;
        n_rd_len    = r_rd_len;
        w_emit      = 1'b0;
        w_st        = ST_OK;
        w_obyte     = '0;
        w_olast     = 1'b1;
        w_we        = 1'b0;
        w_waddr     = w_stg_eff;
        w_re        = 1'b0;
        w_raddr     = r_posm;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_act  = i_item.action;
                    n_byte = i_item.data_byte;
                    n_len  = i_item.length;
                    n_pos  = i_item.position;
                    if (i_item.action == ACT_READ || i_item.action == ACT_FINISH) begin
                        n_state = S_POS1;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_POS1: begin
                n_prod  = r_pos * K_VEC;
                n_state = S_POS2;
            end
            S_POS2: begin
                n_posm  = AW'(w_posm12);
                n_state = S_REL;
            end
            S_REL: begin
                n_rel   = w_rel_sum[AW-1:0];
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                    w_emit  = 1'b1;
                    case (r_act)
                        ACT_WRITE: begin
                            if (r_burst_rem == '0 && r_len == '0) begin
                                // empty burst opens nothing
                                w_st = ST_INVAL;
                            end else begin
                                n_burst_rem = w_len_eff - FIELD_W'(1);
                                n_blen      = w_blen_eff;
                                if (w_rej_eff) begin
                                    w_st        = ST_NOSPACE;
                                    n_burst_rej = (n_burst_rem != '0);
                                end else begin
                                    w_st        = ST_OK;
                                    w_we        = 1'b1;
                                    n_burst_rej = 1'b0;
                                    n_stg       = f_inc(w_stg_eff);
                                    if (n_burst_rem == '0) begin
                                        // commit the burst
                                        n_cw   = f_inc(w_stg_eff);
                                        n_used = r_used + w_blen_eff;
                                    end
                                end
                            end
                        end
                        ACT_READ: begin
                            if (r_len == '0) begin
                                w_st = ST_INVAL;
                            end else if (r_len > FIELD_W'(READ_MAX) ||
                                         w_rd_end > (W+1)'(r_used)) begin
                                w_st = ST_SIZE;
                            end else begin
                                // start the run: first byte read now
                                w_emit    = 1'b0;
                                w_re      = 1'b1;
                                w_raddr   = r_posm;
                                n_rd_addr = r_posm;
                                n_rd_cnt  = '0;
                                n_rd_len  = CW'(r_len);
                                n_state   = S_RDOUT;
                            end
                        end
                        ACT_FINISH: begin
                            if (r_rel <= r_used) begin
                                w_st   = ST_OK;
                                n_rp   = r_posm;
                                n_used = r_used - r_rel;
                            end else begin
                                w_st = ST_IGNORED;
                            end
                        end
                        default: begin
                            w_st = ST_OK;
                        end
                    endcase
                end
            end
            S_RDOUT: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_st    = ST_OK;
                    w_obyte = r_mem_q;
                    w_olast = ((r_rd_cnt + CW'(1)) == r_rd_len);
                    if (w_olast) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next byte while this one goes out
                        w_re      = 1'b1;
                        w_raddr   = f_inc(r_rd_addr);
                        n_rd_addr = f_inc(r_rd_addr);
                        n_rd_cnt  = r_rd_cnt + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // counters after the request, as reported
    assign w_free   = B_LAST - n_used;
    assign w_wp_w   = W'(n_cw);
    assign w_free_w = W'(w_free);
    assign w_used_w = W'(n_used);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cw        <= '0;
            r_rp        <= '0;
            r_stg       <= '0;
            r_used      <= '0;
            r_burst_rem <= '0;
            r_burst_rej <= 1'b0;
            r_blen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cw        <= n_cw;
            r_rp        <= n_rp;
            r_stg       <= n_stg;
            r_used      <= n_used;
            r_burst_rem <= n_burst_rem;
            r_burst_rej <= n_burst_rej;
            r_blen      <= n_blen;
            r_out_valid <= n_out_valid;
        end
        r_act     <= n_act;
        r_byte    <= n_byte;
        r_len     <= n_len;
        r_pos     <= n_pos;
        r_prod    <= n_prod;
        r_posm    <= n_posm;
        r_rel     <= n_rel;
        r_rd_addr <= n_rd_addr;
        r_rd_cnt  <= n_rd_cnt;
        r_rd_len  <= n_rd_len;
        if (w_emit) begin
            r_o_status <= w_st;
            r_o_byte   <= w_obyte;
            r_o_last   <= w_olast;
            r_o_wp     <= w_wp_w[FIELD_W-1:0];
            r_o_free   <= w_free_w[FIELD_W-1:0];
            r_o_used   <= w_used_w[FIELD_W-1:0];
        end
    end

    // byte memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_mem_q <= r_store[w_raddr];
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_o_status;
    assign o_result.read_byte      = r_o_byte;
    assign o_result.last           = r_o_last;
    assign o_result.write_position = r_o_wp;
    assign o_result.free_bytes     = r_o_free;
    assign o_result.used_bytes     = r_o_used;

    // used count never reaches the full ring size
    `FRB_ASSERT_IMPL(a_used_range, i_clk, i_rst_n, 1'b1, r_used <= B_LAST,
                     "used count beyond capacity")
    // a read run never outlives its length
    `FRB_ASSERT_IMPL(a_run_count, i_clk, i_rst_n, r_state == S_RDOUT,
                     r_rd_cnt < r_rd_len, "read run count past length")
    // the final byte of a run frees the block for the next request
    `FRB_ASSERT_NEXT(a_run_end, i_clk, i_rst_n, w_emit && r_state == S_RDOUT && w_olast,
                     r_state == S_IDLE, "read run did not end")
    // a rejected burst is always an open burst
    `FRB_ASSERT_IMPL(a_rej_open, i_clk, i_rst_n, r_burst_rej, r_burst_rem != '0,
                     "rejected burst without open burst")

endmodule
